// ===== hw/rtl/ers_pkg.sv =====
// Package for the elevator request scheduler: field widths, codes and
// the command/status bundles between controller and datapath. No dependencies.
`default_nettype none
package ers_pkg;

	localparam int MAX_FLOORS_DEF = 64;
	localparam int TIMER_W_DEF    = 16;

	localparam int FLOOR_W = 7;
	localparam int DIR_W   = 2;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int WALK_W  = 8;

	localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
	localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
	localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOOR_TICKS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_TICKS = 2'd2;

	typedef struct packed {
		logic latch;
		logic walk;
		logic apply;
	} ers_cmd_t;

	typedef struct packed {
		logic need_search;
		logic hit;
	} ers_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ers_in_if.sv =====
// Input channel of the elevator request scheduler: valid/ready plus item.
// Depends on ers_pkg.
`default_nettype none
interface ers_in_if;
	import ers_pkg::*;
	logic               valid;
	logic               ready;
	logic               operation;
	logic [FLOOR_W-1:0] request_floor;
	modport source (output valid, operation, request_floor, input ready);
	modport sink (input valid, operation, request_floor, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ers_out_if.sv =====
// Result channel of the elevator request scheduler: valid/ready plus status.
// Depends on ers_pkg.
`default_nettype none
interface ers_out_if;
	import ers_pkg::*;
	logic               valid;
	logic               ready;
	logic               accepted;
	logic [FLOOR_W-1:0] car_floor;
	logic [FLOOR_W-1:0] goal_floor;
	logic               in_motion;
	logic               doors_are_open;
	logic [DIR_W-1:0]   heading;
	logic [FLOOR_W-1:0] pending_count;
	logic               arrived;
	modport source (output valid, accepted, car_floor, goal_floor, in_motion,
		doors_are_open, heading, pending_count, arrived, input ready);
	modport sink (input valid, accepted, car_floor, goal_floor, in_motion,
		doors_are_open, heading, pending_count, arrived, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ers_ctrl.sv =====
// Controller of the elevator request scheduler: sequences latch, service
// order walk and apply, and owns the result valid. Depends on ers_pkg.
`default_nettype none
module ers_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire ers_pkg::ers_sts_t sts,
	output ers_pkg::ers_cmd_t      cmd
);
	import ers_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_APPLY  = 2'd2;

	logic [1:0] state_q, state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d   = state_q;
		cmd.latch = 1'b0;
		cmd.walk  = 1'b0;
		cmd.apply = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_SEARCH;
				end
			end
			S_SEARCH: begin
				// walk the service order until the first pending floor
				cmd.walk = sts.need_search;
				if (!sts.need_search || sts.hit)
					state_d = S_APPLY;
			end
			S_APPLY: begin
				if (slot_free) begin
					cmd.apply = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.apply)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/ers_datapath.sv =====
// Datapath of the elevator request scheduler: config registers, car state,
// pending floor map, service order walker and result register. Depends on ers_pkg.
`default_nettype none
module ers_datapath #(
	parameter int MaxFloors = ers_pkg::MAX_FLOORS_DEF,
	parameter int TimerW    = ers_pkg::TIMER_W_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [ers_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ers_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          in_operation,
	input  wire logic [ers_pkg::FLOOR_W-1:0]   in_floor,
	input  wire ers_pkg::ers_cmd_t             cmd,
	output ers_pkg::ers_sts_t                  sts,
	output logic                               out_accepted,
	output logic [ers_pkg::FLOOR_W-1:0]        out_car_floor,
	output logic [ers_pkg::FLOOR_W-1:0]        out_goal_floor,
	output logic                               out_in_motion,
	output logic                               out_doors_are_open,
	output logic [ers_pkg::DIR_W-1:0]          out_heading,
	output logic [ers_pkg::FLOOR_W-1:0]        out_pending_count,
	output logic                               out_arrived
);
	import ers_pkg::*;

	localparam int IDX_W = (MaxFloors > 1) ? $clog2(MaxFloors) : 1;
	localparam int CMP_W = (TimerW > CFG_W) ? TimerW : CFG_W;
	localparam logic [FLOOR_W-1:0] MAX_F = FLOOR_W'(MaxFloors);

	// configuration
	logic [FLOOR_W-1:0] floor_count_q;
	logic [CFG_W-1:0]   door_ticks_q, travel_ticks_q;
	// car state
	logic [FLOOR_W-1:0] car_q, goal_q;
	logic               moving_q, door_q;
	logic [DIR_W-1:0]   dir_q;
	logic [TimerW-1:0]  move_t_q, door_t_q;
	logic [MaxFloors-1:0] pend_q;
	logic [FLOOR_W-1:0] count_q;
	// order in force since the last accepted request
	logic [FLOOR_W-1:0] order_car_q;
	logic [DIR_W-1:0]   order_dir_q;
	// latched item and walker
	logic               op_q;
	logic [FLOOR_W-1:0] req_q;
	logic [WALK_W-1:0]  k_q;
	logic [FLOOR_W-1:0] head_q;

	function automatic logic [TimerW-1:0] t_adv(input logic [TimerW-1:0] t);
		return (t == {TimerW{1'b1}}) ? t : t + 1'b1;
	endfunction

	function automatic logic t_done(input logic [TimerW-1:0] t,
			input logic [CFG_W-1:0] lim);
		return (CMP_W'(t) >= CMP_W'(lim)) || (t == {TimerW{1'b1}});
	endfunction

	function automatic logic [IDX_W-1:0] fidx(input logic [FLOOR_W-1:0] f);
		logic [FLOOR_W-1:0] m;
		m = f - 1'b1;
		return m[IDX_W-1:0];
	endfunction

	logic [FLOOR_W-1:0] usable;
	assign usable = (floor_count_q > MAX_F) ? MAX_F : floor_count_q;

	// candidate floor at walk position k
	logic signed [9:0] cs, ks, ms, fs;
	logic              cand_ok;
	logic [FLOOR_W-1:0] cand;
	always_comb begin
		cs = signed'({3'b000, order_car_q});
		ks = signed'({2'b00, k_q});
		ms = signed'({3'b000, MAX_F});
		case (order_dir_q)
			DIR_UP:   fs = (ks <= ms - cs) ? cs + ks : ms - ks;
			DIR_DOWN: fs = (ks < cs) ? cs - ks : ks + 10'sd1;
			default: begin
				if (ks == 10'sd0)
					fs = cs;
				else if (ks[0])
					fs = cs - ((ks + 10'sd1) >>> 1);
				else
					fs = cs + (ks >>> 1);
			end
		endcase
		cand_ok = (fs >= 10'sd1) && (fs <= ms);
		cand    = fs[FLOOR_W-1:0];
	end

	assign sts.hit = cand_ok && pend_q[fidx(cand)];
	assign sts.need_search = (op_q == OP_TICK) && !moving_q && (count_q != '0);

	// next state for the latched item
	logic               n_acc, n_arr, n_moving, n_door;
	logic [FLOOR_W-1:0] n_car, n_goal, n_count;
	logic [DIR_W-1:0]   n_dir;
	logic [TimerW-1:0]  n_move_t, n_door_t;
	logic [MaxFloors-1:0] n_pend;
	logic               drop_en;
	logic [FLOOR_W-1:0] drop_f;
	logic               req_ok;

	assign req_ok = (req_q != '0) && (req_q <= usable) && !pend_q[fidx(req_q)];

	always_comb begin
		n_acc = 1'b0; n_arr = 1'b0;
		n_moving = moving_q; n_door = door_q;
		n_car = car_q; n_goal = goal_q; n_dir = dir_q;
		n_move_t = move_t_q; n_door_t = door_t_q;
		n_pend = pend_q; n_count = count_q;
		drop_en = 1'b0; drop_f = head_q;
		if (op_q == OP_REQUEST) begin
			if (req_ok) begin
				n_acc = 1'b1;
				n_pend[fidx(req_q)] = 1'b1;
				n_count = count_q + 1'b1;
			end
		end else begin
			if (door_q) begin
				n_door_t = t_adv(door_t_q);
				if (t_done(n_door_t, door_ticks_q))
					n_door = 1'b0;
			end
			if (moving_q) begin
				n_move_t = t_adv(move_t_q);
				if (t_done(n_move_t, travel_ticks_q)) begin
					n_car = goal_q;
					n_moving = 1'b0;
					n_door = 1'b1;
					n_door_t = '0;
					n_arr = 1'b1;
					drop_en = 1'b1;
					drop_f = goal_q;
				end
			end else if (count_q != '0) begin
				if (head_q == car_q) begin
					n_door = 1'b1;
					n_door_t = '0;
					drop_en = 1'b1;
				end else if (head_q > usable) begin
					drop_en = 1'b1;
				end else begin
					n_goal = head_q;
					n_moving = 1'b1;
					n_dir = (head_q > car_q) ? DIR_UP : DIR_DOWN;
					n_move_t = '0;
				end
			end
			if (drop_en && (drop_f != '0) && (drop_f <= MAX_F) && pend_q[fidx(drop_f)]) begin
				n_pend[fidx(drop_f)] = 1'b0;
				n_count = count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_count_q  <= FLOOR_W'(16);
			door_ticks_q   <= CFG_W'(150);
			travel_ticks_q <= CFG_W'(200);
			car_q       <= FLOOR_W'(1);
			goal_q      <= FLOOR_W'(1);
			moving_q    <= 1'b0;
			door_q      <= 1'b0;
			dir_q       <= DIR_NONE;
			move_t_q    <= '0;
			door_t_q    <= '0;
			pend_q      <= '0;
			count_q     <= '0;
			order_car_q <= FLOOR_W'(1);
			order_dir_q <= DIR_NONE;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FLOOR_COUNT:  floor_count_q  <= cfg_data[FLOOR_W-1:0];
					REG_DOOR_TICKS:   door_ticks_q   <= cfg_data;
					REG_TRAVEL_TICKS: travel_ticks_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.apply) begin
				car_q    <= n_car;
				goal_q   <= n_goal;
				moving_q <= n_moving;
				door_q   <= n_door;
				dir_q    <= n_dir;
				move_t_q <= n_move_t;
				door_t_q <= n_door_t;
				pend_q   <= n_pend;
				count_q  <= n_count;
				// a queued request rebuilds the order from the current car and heading
				if (n_acc) begin
					order_car_q <= car_q;
					order_dir_q <= dir_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= in_operation;
			req_q <= in_floor;
			k_q   <= '0;
		end else if (cmd.walk) begin
			head_q <= cand;
			k_q    <= k_q + 1'b1;
		end
		if (cmd.apply) begin
			out_accepted       <= n_acc;
			out_car_floor      <= n_car;
			out_goal_floor     <= n_goal;
			out_in_motion      <= n_moving;
			out_doors_are_open <= n_door;
			out_heading        <= n_dir;
			out_pending_count  <= n_count;
			out_arrived        <= n_arr;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/elevator_request_scheduler.sv =====
// Top level of the single-car elevator request scheduler.
// Depends on ers_pkg, ers_in_if, ers_out_if, ers_ctrl and ers_datapath.
//
//  channel  | direction | handshake      | payload
//  ---------+-----------+----------------+------------------------------------
//  item     | in        | valid / ready  | operation, request_floor
//  result   | out       | valid / ready  | accepted, car_floor, goal_floor,
//           |           |                | in_motion, doors_are_open, heading,
//           |           |                | pending_count, arrived
//  cfg      | in        | cfg_we         | cfg_index, cfg_data
//
// Sequencing: one item at a time: latch, search, apply. A request, or a tick
// that finds the car moving or nothing queued, skips the walk; a tick that
// starts service walks the service order one position per cycle up to the
// head, using the single order walker in the datapath. Reset: asynchronous,
// active low; config returns to 16 floors, 150 and 200 ticks. No clearing
// pass. Stalls: the result register holds a finished transfer while the next
// item is taken; apply waits only if it is still full.
`default_nettype none
module elevator_request_scheduler #(
	parameter int MaxFloors = ers_pkg::MAX_FLOORS_DEF,
	parameter int TimerW    = ers_pkg::TIMER_W_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	ers_in_if.sink                             item,
	ers_out_if.source                          result,
	input  wire logic                          cfg_we,
	input  wire logic [ers_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ers_pkg::CFG_W-1:0]     cfg_data
);
	import ers_pkg::*;

	ers_cmd_t cmd;
	ers_sts_t sts;

	// sequence each item: latch, optional order walk, apply into result register
	ers_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// hold car state, pending map and the result payload
	ers_datapath #(
		.MaxFloors (MaxFloors),
		.TimerW    (TimerW)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_operation       (item.operation),
		.in_floor           (item.request_floor),
		.cmd                (cmd),
		.sts                (sts),
		.out_accepted       (result.accepted),
		.out_car_floor      (result.car_floor),
		.out_goal_floor     (result.goal_floor),
		.out_in_motion      (result.in_motion),
		.out_doors_are_open (result.doors_are_open),
		.out_heading        (result.heading),
		.out_pending_count  (result.pending_count),
		.out_arrived        (result.arrived)
	);

	// an accepted item closes the input in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("input ready right after a transfer");

	// a moving car always has a heading
	a_motion_heading: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.in_motion |-> result.heading != DIR_NONE)
		else $error("car in motion with no heading");

	// an arrival stops the car, opens the doors and is never a request
	a_arrival: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.arrived |->
			!result.in_motion && result.doors_are_open && !result.accepted)
		else $error("inconsistent arrival result");

	// apply only happens from the apply state with the result slot free
	a_apply_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |-> !result.valid || result.ready)
		else $error("result overwritten before transfer");

endmodule
`default_nettype wire
